>>> design/llot_pkg.sv
// ----------------------------------------------------------------------------
// llot_pkg
// Shared sizes, operation codes and status codes for the owner table.
// ----------------------------------------------------------------------------
package llot_pkg;

  localparam int SLOTS  = 16;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = IDX_W + 1;
  localparam int ID_W   = 64;
  localparam int LOAD_W = 10;
  localparam int MODE_W = 3;
  localparam int STAT_W = 2;

  localparam logic [LOAD_W-1:0] LOAD_LIMIT = LOAD_W'(1000);
  localparam logic [LOAD_W-1:0] LOAD_MAX   = LOAD_W'(1023);

  localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INC    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DEC    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FIND   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE    = 2'd1;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

endpackage

>>> design/llot_if.sv
// ----------------------------------------------------------------------------
// llot_if
// Valid/ready channels for the owner table: operation beats in, results out.
// ----------------------------------------------------------------------------
interface llot_in_if;
  logic                          valid;
  logic                          ready;
  logic [llot_pkg::MODE_W-1:0]   mode;
  logic [llot_pkg::ID_W-1:0]     owner_id;

  modport source (output valid, output mode, output owner_id, input ready);
  modport sink   (input valid, input mode, input owner_id, output ready);
endinterface

interface llot_out_if;
  logic                          valid;
  logic                          ready;
  logic [llot_pkg::STAT_W-1:0]   status;
  logic                          hit;
  logic [llot_pkg::ID_W-1:0]     chosen_id;

  modport source (output valid, output status, output hit, output chosen_id, input ready);
  modport sink   (input valid, input status, input hit, input chosen_id, output ready);
endinterface

>>> design/least_loaded_owner_table.sv
// ----------------------------------------------------------------------------
// least_loaded_owner_table
// Owner table with add/remove/load adjust/query and least-loaded search.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                        | handshake
//  ---------+-----+--------------------------------+------------
//  in_ch    | in  | mode[2:0], owner_id[63:0]      | valid/ready
//  out_ch   | out | status[1:0], hit, chosen_id    | valid/ready
//
//  each beat runs through accept, a scan that reads all SLOTS slots of the slot memory
//  through one compare unit with registered read data, and then the update step
//  in_ch.ready is high only while idle; a pending result does not block it
//  the update cycle waits while the previous result is still not taken
//  rst_n clears the valid bits at once; ids and loads need no clearing
// ----------------------------------------------------------------------------
module least_loaded_owner_table (
  input  logic             clk,
  input  logic             rst_n,
  llot_in_if.sink          in_ch,
  llot_out_if.source       out_ch
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY} state_t;

  state_t                          state_r, state_nxt;
  logic [llot_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            eval_v_r, eval_v_nxt;
  logic [llot_pkg::IDX_W-1:0]      eval_idx_r, eval_idx_nxt;

  logic [llot_pkg::MODE_W-1:0]     op_mode_r, op_mode_nxt;
  logic [llot_pkg::ID_W-1:0]       op_id_r, op_id_nxt;
  logic                            id_zero_r, id_zero_nxt;

  logic                            match_r, match_nxt;
  logic [llot_pkg::IDX_W-1:0]      at_r, at_nxt;
  logic [llot_pkg::LOAD_W-1:0]     at_load_r, at_load_nxt;
  logic                            free_found_r, free_found_nxt;
  logic [llot_pkg::IDX_W-1:0]      free_idx_r, free_idx_nxt;
  logic                            cand_r, cand_nxt;
  logic [llot_pkg::LOAD_W-1:0]     best_load_r, best_load_nxt;
  logic [llot_pkg::ID_W-1:0]       best_id_r, best_id_nxt;

  logic [llot_pkg::SLOTS-1:0]      slot_valid_r, slot_valid_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [llot_pkg::STAT_W-1:0]     out_status_r, out_status_nxt;
  logic                            out_hit_r, out_hit_nxt;
  logic [llot_pkg::ID_W-1:0]       out_chosen_r, out_chosen_nxt;

  // slot memory
  logic [llot_pkg::ID_W-1:0]       slot_id_mem   [llot_pkg::SLOTS];
  logic [llot_pkg::LOAD_W-1:0]     slot_load_mem [llot_pkg::SLOTS];
  logic [llot_pkg::ID_W-1:0]       rd_id_r;
  logic [llot_pkg::LOAD_W-1:0]     rd_load_r;
  logic [llot_pkg::IDX_W-1:0]      rd_addr;
  logic                            wr_en;
  logic [llot_pkg::IDX_W-1:0]      wr_addr;
  logic [llot_pkg::ID_W-1:0]       wr_id;
  logic [llot_pkg::LOAD_W-1:0]     wr_load;

  logic                            in_beat;
  logic                            out_busy;
  logic                            sv;
  logic                            better;

  assign in_ch.ready      = (state_r == S_IDLE);
  assign in_beat          = in_ch.valid && in_ch.ready;
  assign out_busy         = out_valid_r && !out_ch.ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.hit       = out_hit_r;
  assign out_ch.chosen_id = out_chosen_r;

  assign rd_addr = cnt_r[llot_pkg::IDX_W-1:0];
  assign sv      = slot_valid_r[eval_idx_r];
  assign better  = sv && ((rd_load_r < best_load_r) ||
                   (cand_r && (rd_load_r == best_load_r) && (rd_id_r < best_id_r)));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_id_mem[wr_addr]   <= wr_id;
      slot_load_mem[wr_addr] <= wr_load;
    end
    rd_id_r   <= slot_id_mem[rd_addr];
    rd_load_r <= slot_load_mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    eval_v_nxt     = 1'b0;
    eval_idx_nxt   = rd_addr;
    op_mode_nxt    = op_mode_r;
    op_id_nxt      = op_id_r;
    id_zero_nxt    = id_zero_r;
    match_nxt      = match_r;
    at_nxt         = at_r;
    at_load_nxt    = at_load_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    cand_nxt       = cand_r;
    best_load_nxt  = best_load_r;
    best_id_nxt    = best_id_r;
    slot_valid_nxt = slot_valid_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_hit_nxt    = out_hit_r;
    out_chosen_nxt = out_chosen_r;
    wr_en          = 1'b0;
    wr_addr        = at_r;
    wr_id          = op_id_r;
    wr_load        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          op_mode_nxt    = in_ch.mode;
          op_id_nxt      = in_ch.owner_id;
          id_zero_nxt    = (in_ch.owner_id == '0);
          match_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          cand_nxt       = 1'b0;
          best_load_nxt  = llot_pkg::LOAD_LIMIT;
          best_id_nxt    = '0;
          cnt_nxt        = '0;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        // issue one read a cycle, judge it in the cycle after
        if (cnt_r != llot_pkg::CNT_W'(llot_pkg::SLOTS)) begin
          eval_v_nxt = 1'b1;
          cnt_nxt    = cnt_r + 1'b1;
        end else begin
          state_nxt = S_APPLY;
        end
        if (eval_v_r) begin
          if (sv && !id_zero_r && (rd_id_r == op_id_r) && !match_r) begin
            match_nxt   = 1'b1;
            at_nxt      = eval_idx_r;
            at_load_nxt = rd_load_r;
          end
          if (!sv && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = eval_idx_r;
          end
          if (better) begin
            cand_nxt      = 1'b1;
            best_load_nxt = rd_load_r;
            best_id_nxt   = rd_id_r;
          end
        end
      end
      S_APPLY: begin
        if (!out_busy) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = llot_pkg::ST_NONE;
          out_hit_nxt    = 1'b0;
          out_chosen_nxt = '0;
          state_nxt      = S_IDLE;
          case (op_mode_r)
            llot_pkg::MODE_ADD: begin
              if (id_zero_r) begin
                out_status_nxt = llot_pkg::ST_INVALID;
              end else if (match_r) begin
                wr_en          = 1'b1;
                out_status_nxt = llot_pkg::ST_OK;
              end else if (free_found_r) begin
                wr_en                      = 1'b1;
                wr_addr                    = free_idx_r;
                slot_valid_nxt[free_idx_r] = 1'b1;
                out_status_nxt             = llot_pkg::ST_OK;
              end else begin
                out_status_nxt = llot_pkg::ST_FULL;
              end
            end
            llot_pkg::MODE_REMOVE: begin
              if (match_r) begin
                slot_valid_nxt[at_r] = 1'b0;
                out_status_nxt       = llot_pkg::ST_OK;
              end
            end
            llot_pkg::MODE_INC: begin
              if (match_r) begin
                wr_en          = 1'b1;
                wr_load        = (at_load_r == llot_pkg::LOAD_MAX) ? at_load_r
                                                                   : at_load_r + 1'b1;
                out_status_nxt = llot_pkg::ST_OK;
              end
            end
            llot_pkg::MODE_DEC: begin
              if (match_r) begin
                wr_en          = 1'b1;
                wr_load        = (at_load_r == '0) ? at_load_r : at_load_r - 1'b1;
                out_status_nxt = llot_pkg::ST_OK;
              end
            end
            llot_pkg::MODE_FIND: begin
              if (cand_r) begin
                out_status_nxt = llot_pkg::ST_OK;
                out_hit_nxt    = 1'b1;
                out_chosen_nxt = best_id_r;
              end
            end
            llot_pkg::MODE_QUERY: begin
              if (match_r) begin
                out_status_nxt = llot_pkg::ST_OK;
                out_hit_nxt    = 1'b1;
              end
            end
            default: begin
              out_status_nxt = llot_pkg::ST_NONE;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      eval_v_r     <= 1'b0;
      slot_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      eval_v_r     <= eval_v_nxt;
      slot_valid_r <= slot_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    eval_idx_r   <= eval_idx_nxt;
    op_mode_r    <= op_mode_nxt;
    op_id_r      <= op_id_nxt;
    id_zero_r    <= id_zero_nxt;
    match_r      <= match_nxt;
    at_r         <= at_nxt;
    at_load_r    <= at_load_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    cand_r       <= cand_nxt;
    best_load_r  <= best_load_nxt;
    best_id_r    <= best_id_nxt;
    out_status_r <= out_status_nxt;
    out_hit_r    <= out_hit_nxt;
    out_chosen_r <= out_chosen_nxt;
  end

`ifndef ASSERT_OFF
  a_beat_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> (state_r == S_SCAN) && (cnt_r == '0))
    else $error("accepted beat did not start a scan at slot zero");

  a_apply_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) && out_busy |=> (state_r == S_APPLY) && $stable(out_status_r))
    else $error("update ran over an untaken result");

  a_apply_posts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) && !out_busy |=> out_valid_r && (state_r == S_IDLE))
    else $error("update cycle did not post a result");

  a_free_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) && free_found_r |-> !slot_valid_r[free_idx_r])
    else $error("chosen free slot is occupied");

  a_match_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) && match_r |-> slot_valid_r[at_r] && !id_zero_r)
    else $error("matched slot is not a valid owner");
`endif

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Sends directed and random owner-table operations through the input channel
// and checks each result beat against a behavioral table kept in the bench.
// The run passes through phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [llot_pkg::MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [llot_pkg::MODE_W-1:0] MODE_SPARE7 = 3'd7;

  localparam int POOL_N           = 24;
  localparam int RANDOM_PER_PHASE = 70;
  localparam int LONG_HOLD        = 400;
  localparam int BEAT_CYCLES      = llot_pkg::SLOTS + 3;
  localparam int STALL_LIMIT      = 10 * LONG_HOLD;
  localparam int SHOWN_FAILS      = 10;

  typedef struct packed {
    logic [llot_pkg::MODE_W-1:0] mode;
    logic [llot_pkg::ID_W-1:0]   owner_id;
  } op_beat_t;

  typedef struct packed {
    logic [llot_pkg::STAT_W-1:0] status;
    logic                        hit;
    logic [llot_pkg::ID_W-1:0]   chosen_id;
  } result_beat_t;

  logic clk;
  logic rst_n;

  llot_in_if  in_ch ();
  llot_out_if out_ch ();

  least_loaded_owner_table DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // bench copy of the owner table
  logic                        tbl_valid [llot_pkg::SLOTS];
  logic [llot_pkg::ID_W-1:0]   tbl_id    [llot_pkg::SLOTS];
  logic [llot_pkg::LOAD_W-1:0] tbl_load  [llot_pkg::SLOTS];

  op_beat_t                  pending_ops[$];
  result_beat_t              expected_results[$];
  logic [llot_pkg::ID_W-1:0] id_pool [POOL_N];

  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  bit long_hold_go    = 1'b0;
  bit long_hold_taken = 1'b0;
  int hold_left       = 0;

  int fail_count      = 0;
  int results_checked = 0;
  int full_count      = 0;
  int sat_count       = 0;
  int find_hits       = 0;
  int mode_beats [8];

  function automatic result_beat_t owner_table_apply(input op_beat_t op);
    result_beat_t                res;
    int                          at;
    bit                          placed;
    bit                          found;
    logic [llot_pkg::LOAD_W-1:0] best_load;
    logic [llot_pkg::ID_W-1:0]   best_id;
    res.status    = llot_pkg::ST_NONE;
    res.hit       = 1'b0;
    res.chosen_id = '0;
    at            = -1;
    placed        = 1'b0;
    found         = 1'b0;
    best_load     = llot_pkg::LOAD_LIMIT;
    best_id       = '0;
    // id 0 is never present; scan downward so the lowest slot wins
    if (op.owner_id != '0) begin
      for (int i = llot_pkg::SLOTS - 1; i >= 0; i--) begin
        if (tbl_valid[i] && tbl_id[i] == op.owner_id) at = i;
      end
    end
    case (op.mode)
      llot_pkg::MODE_ADD: begin
        if (op.owner_id == '0) begin
          res.status = llot_pkg::ST_INVALID;
        end else if (at >= 0) begin
          tbl_load[at] = '0;
          res.status   = llot_pkg::ST_OK;
        end else begin
          res.status = llot_pkg::ST_FULL;
          for (int i = 0; i < llot_pkg::SLOTS; i++) begin
            if (!placed && !tbl_valid[i]) begin
              tbl_valid[i] = 1'b1;
              tbl_id[i]    = op.owner_id;
              tbl_load[i]  = '0;
              placed       = 1'b1;
              res.status   = llot_pkg::ST_OK;
            end
          end
        end
      end
      llot_pkg::MODE_REMOVE: begin
        if (at >= 0) begin
          tbl_valid[at] = 1'b0;
          res.status    = llot_pkg::ST_OK;
        end
      end
      llot_pkg::MODE_INC: begin
        if (at >= 0) begin
          if (tbl_load[at] != llot_pkg::LOAD_MAX) tbl_load[at] = tbl_load[at] + 1'b1;
          else sat_count++;
          res.status = llot_pkg::ST_OK;
        end
      end
      llot_pkg::MODE_DEC: begin
        if (at >= 0) begin
          if (tbl_load[at] != '0) tbl_load[at] = tbl_load[at] - 1'b1;
          res.status = llot_pkg::ST_OK;
        end
      end
      llot_pkg::MODE_FIND: begin
        // only loads below the limit qualify, lowest id breaks a tie
        for (int i = 0; i < llot_pkg::SLOTS; i++) begin
          if (tbl_valid[i] && (tbl_load[i] < best_load ||
              (found && tbl_load[i] == best_load && tbl_id[i] < best_id))) begin
            best_load = tbl_load[i];
            best_id   = tbl_id[i];
            found     = 1'b1;
          end
        end
        if (found) begin
          res.status    = llot_pkg::ST_OK;
          res.hit       = 1'b1;
          res.chosen_id = best_id;
        end
      end
      llot_pkg::MODE_QUERY: begin
        if (at >= 0) begin
          res.status = llot_pkg::ST_OK;
          res.hit    = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic void push_op(input logic [llot_pkg::MODE_W-1:0] mode,
                                  input logic [llot_pkg::ID_W-1:0] id);
    op_beat_t b;
    b.mode     = mode;
    b.owner_id = id;
    pending_ops.push_back(b);
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= SHOWN_FAILS) $display("mismatch: %s", msg);
  endfunction

  // mostly operations on a fixed pool of owners, some fresh ids and id 0
  task automatic queue_random_ops(input int count);
    int pick;
    int r;
    logic [llot_pkg::MODE_W-1:0] mode;
    logic [llot_pkg::ID_W-1:0]   id;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 20)      mode = llot_pkg::MODE_ADD;
      else if (pick < 36) mode = llot_pkg::MODE_REMOVE;
      else if (pick < 58) mode = llot_pkg::MODE_INC;
      else if (pick < 70) mode = llot_pkg::MODE_DEC;
      else if (pick < 85) mode = llot_pkg::MODE_FIND;
      else if (pick < 98) mode = llot_pkg::MODE_QUERY;
      else                mode = ($urandom_range(1) != 0) ? MODE_SPARE7 : MODE_SPARE6;
      r = $urandom_range(99);
      if (r < 85)      id = id_pool[$urandom_range(POOL_N - 1)];
      else if (r < 95) id = {$urandom, $urandom};
      else             id = '0;
      push_op(mode, id);
    end
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    clk            = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.mode     = llot_pkg::MODE_ADD;
    in_ch.owner_id = '0;
    out_ch.ready   = 1'b0;
    forever #10 clk = ~clk;
  end

  // operation driver
  always @(posedge clk) begin : drive_ops
    op_beat_t     taken;
    op_beat_t     nxt;
    result_beat_t res;
    if (!rst_n) begin
      in_ch.valid    <= 1'b0;
      in_ch.mode     <= llot_pkg::MODE_ADD;
      in_ch.owner_id <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken.mode     = in_ch.mode;
        taken.owner_id = in_ch.owner_id;
        res = owner_table_apply(taken);
        expected_results.push_back(res);
        mode_beats[taken.mode]++;
        if (res.status == llot_pkg::ST_FULL) full_count++;
        if (taken.mode == llot_pkg::MODE_FIND && res.hit) find_hits++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_ops.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.mode     <= nxt.mode;
          in_ch.owner_id <= nxt.owner_id;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result checker and receiver stalls
  always @(posedge clk) begin : check_results
    result_beat_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result beat: status %0d hit %0d id %h",
                                 out_ch.status, out_ch.hit, out_ch.chosen_id));
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (out_ch.status !== want.status || out_ch.hit !== want.hit ||
              out_ch.chosen_id !== want.chosen_id)
            note_failure($sformatf(
              "beat %0d: expected status %0d hit %0d id %h, got status %0d hit %0d id %h",
              results_checked, want.status, want.hit, want.chosen_id,
              out_ch.status, out_ch.hit, out_ch.chosen_id));
        end
      end
      if (long_hold_go && !long_hold_taken) begin
        long_hold_taken = 1'b1;
        hold_left       = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ends the run when no beat moves on either channel for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n && !(in_ch.valid && in_ch.ready) && !(out_ch.valid && out_ch.ready))
        quiet_cycles++;
      else
        quiet_cycles = 0;
    end
    $display("no progress for %0d cycles", STALL_LIMIT);
    $display("[least_loaded_owner_table] ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [llot_pkg::ID_W-1:0] ramp_id;
    logic [llot_pkg::ID_W-1:0] spare_id;
    rst_n = 1'b0;
    for (int i = 0; i < llot_pkg::SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_id[i]    = '0;
      tbl_load[i]  = '0;
    end
    for (int m = 0; m < 8; m++) mode_beats[m] = 0;
    // small ids make tie breaks interesting, wide ones exercise every id bit
    for (int k = 0; k < POOL_N; k++) begin
      id_pool[k] = (k < 8) ? llot_pkg::ID_W'($urandom_range(40, 1)) : {$urandom, $urandom};
      if (id_pool[k] == '0) id_pool[k] = 64'd1;
    end

    // directed: empty table, id 0 everywhere, ties, floor, re-add, spare modes
    push_op(llot_pkg::MODE_FIND, '0);
    push_op(llot_pkg::MODE_QUERY, '0);
    push_op(llot_pkg::MODE_ADD, '0);
    push_op(llot_pkg::MODE_REMOVE, '0);
    push_op(llot_pkg::MODE_INC, '0);
    push_op(llot_pkg::MODE_DEC, '0);
    push_op(llot_pkg::MODE_ADD, '1);
    push_op(llot_pkg::MODE_ADD, 64'd1);
    push_op(llot_pkg::MODE_FIND, '1);
    push_op(llot_pkg::MODE_INC, 64'd1);
    push_op(llot_pkg::MODE_FIND, '0);
    push_op(llot_pkg::MODE_DEC, '1);
    push_op(llot_pkg::MODE_ADD, 64'd1);
    push_op(llot_pkg::MODE_FIND, '0);
    push_op(llot_pkg::MODE_QUERY, '1);
    push_op(llot_pkg::MODE_REMOVE, '1);
    push_op(llot_pkg::MODE_QUERY, '1);
    push_op(llot_pkg::MODE_REMOVE, '1);
    push_op(llot_pkg::MODE_INC, '1);
    push_op(MODE_SPARE6, '1);
    push_op(MODE_SPARE7, 64'd1);

    // one owner driven through the find limit up to saturation and back
    ramp_id  = {$urandom, $urandom} | 64'h8000_0000_0000_0000;
    spare_id = ramp_id ^ 64'h1;
    push_op(llot_pkg::MODE_REMOVE, 64'd1);
    push_op(llot_pkg::MODE_ADD, ramp_id);
    for (int n = 1; n <= int'(llot_pkg::LOAD_MAX) + 6; n++) begin
      push_op(llot_pkg::MODE_INC, ramp_id);
      if (n % 128 == 0 ||
          (n >= int'(llot_pkg::LOAD_LIMIT) - 2 && n <= int'(llot_pkg::LOAD_LIMIT) + 1))
        push_op(llot_pkg::MODE_FIND, '0);
    end
    push_op(llot_pkg::MODE_ADD, spare_id);
    push_op(llot_pkg::MODE_FIND, ramp_id);
    push_op(llot_pkg::MODE_REMOVE, spare_id);
    for (int n = 0; n < 26; n++) begin
      push_op(llot_pkg::MODE_DEC, ramp_id);
      push_op(llot_pkg::MODE_FIND, '0);
    end
    queue_random_ops(RANDOM_PER_PHASE);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();

    send_idle_pct  = 69;
    recv_stall_pct = 0;
    queue_random_ops(RANDOM_PER_PHASE);
    wait_drained();

    // receiver holds off at the start while beats keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 69;
    long_hold_go   = 1'b1;
    queue_random_ops(RANDOM_PER_PHASE);
    wait_drained();

    send_idle_pct  = 34;
    recv_stall_pct = 34;
    queue_random_ops(RANDOM_PER_PHASE);
    wait_drained();

    repeat (BEAT_CYCLES + 5) @(negedge clk);

    $display("ops: add %0d remove %0d inc %0d dec %0d find %0d (%0d found) query %0d spare %0d",
             mode_beats[llot_pkg::MODE_ADD], mode_beats[llot_pkg::MODE_REMOVE],
             mode_beats[llot_pkg::MODE_INC], mode_beats[llot_pkg::MODE_DEC],
             mode_beats[llot_pkg::MODE_FIND], find_hits, mode_beats[llot_pkg::MODE_QUERY],
             mode_beats[MODE_SPARE6] + mode_beats[MODE_SPARE7]);
    $display("%0d results checked, %0d adds on a full table, %0d saturated increments, %0d bad",
             results_checked, full_count, sat_count, fail_count);
    if (fail_count == 0) begin
      $display("[least_loaded_owner_table] OK");
    end else begin
      $display("[least_loaded_owner_table] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
design/llot_pkg.sv
design/llot_if.sv
design/least_loaded_owner_table.sv
test/testbench.sv
